// ===== rtl/u2u_pkg.sv =====
// Shared types and constants for the UTF-8 to UCS-2 stream decoder.
`default_nettype none
package u2u_pkg;

  localparam logic [7:0] ASCII_LIMIT = 8'h80;
  localparam logic [7:0] LEAD3_MASK  = 8'hE0;
  localparam logic [7:0] LEAD2_MASK  = 8'hC0;
  localparam logic [7:0] LEAD3_BITS  = 8'h0F;
  localparam logic [7:0] LEAD2_BITS  = 8'h1F;
  localparam logic [7:0] FOLLOW_BITS = 8'h3F;
  localparam logic [7:0] NUL_BYTE    = 8'h00;

  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  // Follower bytes still expected
  typedef logic [1:0] pending_t;

  // One decoded result
  typedef struct packed {
    logic [15:0] char_count;
    logic [15:0] code_point;
    logic        bad_sequence;
    logic        end_of_string;
  } result_t;

  // Handshake between two pipeline stages
  typedef struct packed {
    logic valid;
    logic ready;
  } link_t;

endpackage : u2u_pkg
`default_nettype wire

// ===== rtl/u2u_in_stage.sv =====
// Input register stage: captures one byte request per cycle while the held byte moves on.
`default_nettype none
module u2u_in_stage (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [7:0]   s_tdata,
  input  wire logic         take,
  output u2u_pkg::link_t    link,
  output logic [7:0]        byte_in
);
  import u2u_pkg::*;

  logic full;

  // Accept when empty or when the held byte moves on this cycle
  assign s_tready   = !full || take;
  assign link.valid = full;
  assign link.ready = take;

  // Hold the valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (s_tready) begin
      full <= s_tvalid;
    end
  end

  // Capture the byte
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      byte_in <= s_tdata;
    end
  end

endmodule : u2u_in_stage
`default_nettype wire

// ===== rtl/u2u_core.sv =====
// Decode state and next-result logic for one byte.
`default_nettype none
module u2u_core (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire u2u_pkg::link_t   link,
  input  wire logic [7:0]       byte_in,
  output logic                  emit,
  output u2u_pkg::result_t      result
);
  import u2u_pkg::*;

  pending_t    bytes_pending, bytes_pending_next;
  logic [15:0] partial_value, partial_value_next;
  logic [15:0] emitted_count, emitted_count_next;
  logic [15:0] count_bump;
  logic [15:0] follow_add;
  logic [15:0] merged;
  pending_t    pending_dec;
  logic        fire;

  assign fire        = link.valid && link.ready;
  assign count_bump  = (emitted_count == COUNT_MAX) ? emitted_count : emitted_count + 16'd1;
  assign pending_dec = bytes_pending - 2'd1;
  assign merged      = partial_value | follow_add;

  // Place follower bits by how many bytes remain after this one
  always_comb begin
    case (pending_dec)
      2'd0:    follow_add = {10'd0, byte_in[5:0] & FOLLOW_BITS[5:0]};
      2'd1:    follow_add = {4'd0, byte_in[5:0] & FOLLOW_BITS[5:0], 6'd0};
      2'd2:    follow_add = {byte_in[3:0] & FOLLOW_BITS[3:0], 12'd0};
      default: follow_add = 16'd0;
    endcase
  end

  // Next state and result for the byte at the head
  always_comb begin
    bytes_pending_next   = bytes_pending;
    partial_value_next   = partial_value;
    emitted_count_next   = emitted_count;
    emit                 = 1'b0;
    result.code_point    = 16'd0;
    result.bad_sequence  = 1'b0;
    result.end_of_string = 1'b0;
    result.char_count    = emitted_count;
    if (byte_in == NUL_BYTE) begin
      emit                 = 1'b1;
      result.bad_sequence  = (bytes_pending != 2'd0);
      result.end_of_string = 1'b1;
      bytes_pending_next   = 2'd0;
      partial_value_next   = 16'd0;
      emitted_count_next   = 16'd0;
    end else if (bytes_pending == 2'd0) begin
      if (byte_in < ASCII_LIMIT) begin
        emit               = 1'b1;
        emitted_count_next = count_bump;
        result.code_point  = {8'd0, byte_in};
        result.char_count  = count_bump;
      end else if ((byte_in & LEAD3_MASK) == LEAD3_MASK) begin
        partial_value_next = {byte_in[3:0] & LEAD3_BITS[3:0], 12'd0};
        bytes_pending_next = 2'd2;
      end else if ((byte_in & LEAD2_MASK) == LEAD2_MASK) begin
        partial_value_next = {5'd0, byte_in[4:0] & LEAD2_BITS[4:0], 6'd0};
        bytes_pending_next = 2'd1;
      end else begin
        emit                = 1'b1;
        result.bad_sequence = 1'b1;
      end
    end else begin
      bytes_pending_next = pending_dec;
      if (pending_dec == 2'd0) begin
        emit               = 1'b1;
        partial_value_next = 16'd0;
        emitted_count_next = count_bump;
        result.code_point  = merged;
        result.char_count  = count_bump;
      end else begin
        partial_value_next = merged;
      end
    end
  end

  // Advance state on each consumed byte
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_pending <= 2'd0;
      partial_value <= 16'd0;
      emitted_count <= 16'd0;
    end else if (fire) begin
      bytes_pending <= bytes_pending_next;
      partial_value <= partial_value_next;
      emitted_count <= emitted_count_next;
    end
  end

endmodule : u2u_core
`default_nettype wire

// ===== rtl/u2u_out_stage.sv =====
// Output result register toward the downstream side.
`default_nettype none
module u2u_out_stage (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire logic              emit,
  input  wire u2u_pkg::result_t  result,
  output logic                   take,
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output logic [31:0]            m_tdata,
  output logic                   m_tlast,
  output logic [0:0]             m_tuser
);
  import u2u_pkg::*;

  result_t held;
  logic    load;

  // Consume the head byte when the register is free or drains this cycle
  assign take = in_valid && (!m_tvalid || m_tready);
  assign load = take && emit;

  // Hold the valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (take) begin
      m_tvalid <= emit;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Capture the result
  always_ff @(posedge clk) begin
    if (load) begin
      held <= result;
    end
  end

  assign m_tdata    = {held.char_count, held.code_point};
  assign m_tlast    = held.end_of_string;
  assign m_tuser[0] = held.bad_sequence;

endmodule : u2u_out_stage
`default_nettype wire

// ===== rtl/utf8_to_ucs2_stream_decoder_unit.sv =====
// Top level of the UTF-8 to UCS-2 stream decoder.
// An accepted byte waits in the input register; its result, if any, enters
// the result register once free. Throughput: one byte per cycle through the
// input register, decode logic and result register while results are taken.
// Reset: synchronous, clears both stage valid flags, the pending count, the
// partial value and the character count.
`default_nettype none
module utf8_to_ucs2_stream_decoder_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] byte_in
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,   // [15:0] code_point, [31:16] char_count
  output logic             m_tlast,   // end_of_string
  output logic [0:0]       m_tuser    // [0] bad_sequence
);
  import u2u_pkg::*;

  link_t       link;
  logic [7:0]  byte_in;
  logic        take;
  logic        emit;
  result_t     result;

  u2u_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .take     (take),
    .link     (link),
    .byte_in  (byte_in)
  );

  u2u_core u_core (
    .clk     (clk),
    .rst     (rst),
    .link    (link),
    .byte_in (byte_in),
    .emit    (emit),
    .result  (result)
  );

  u2u_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .in_valid (link.valid),
    .emit     (emit),
    .result   (result),
    .take     (take),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule : utf8_to_ucs2_stream_decoder_unit
`default_nettype wire

// ===== rtl/u2u_checker.sv =====
// Port-level checks for the decoder, bound to the top level.
`default_nettype none
module u2u_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [31:0] m_tdata,
  input wire logic        m_tlast,
  input wire logic [0:0]  m_tuser
);

  // A stalled result request holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
      && $stable(m_tuser))
    else $error("result changed while stalled");

  // No result right after reset
  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("result valid right after reset");

  // Error and end results carry a zero code point
  a_zero_cp: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tlast || m_tuser[0]) |-> m_tdata[15:0] == 16'd0)
    else $error("nonzero code point on error or end result");

  // A decoded character always counts at least itself
  a_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast && !m_tuser[0] |-> m_tdata[31:16] != 16'd0)
    else $error("character result with zero count");

endmodule : u2u_checker

bind utf8_to_ucs2_stream_decoder_unit u2u_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .m_tuser  (m_tuser)
);
`default_nettype wire

// ===== tb/sv/utf8_to_ucs2_stream_decoder_unit_tb.sv =====
// Self-checking testbench for the UTF-8 to UCS-2 stream decoder.
module utf8_to_ucs2_stream_decoder_unit_tb;
  import u2u_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int RANDOM_BYTES = 400;
  localparam int SHOWN_ERRORS = 10;

  // Tracks decoder state and the code points still owed by the block
  class code_point_board;
    pending_t    follow_left;
    logic [15:0] gathered;
    logic [15:0] chars_seen;
    result_t     owed[$];
    int          errors;

    function new();
      follow_left = '0;
      gathered    = '0;
      chars_seen  = '0;
      errors      = 0;
    endfunction

    function void owe(logic [15:0] cp, logic bad, logic eos);
      result_t r;
      r.code_point    = cp;
      r.bad_sequence  = bad;
      r.end_of_string = eos;
      r.char_count    = chars_seen;
      owed.push_back(r);
    endfunction

    function void count_char();
      if (chars_seen != COUNT_MAX) chars_seen = chars_seen + 16'd1;
    endfunction

    // Advance the decoder state by one accepted byte request
    function void take_byte(logic [7:0] b);
      pending_t    left_after;
      int unsigned shift;
      if (b == NUL_BYTE) begin
        owe(16'h0000, follow_left != 2'd0, 1'b1);
        follow_left = '0;
        gathered    = '0;
        chars_seen  = '0;
      end else if (follow_left == 2'd0) begin
        if (b < ASCII_LIMIT) begin
          count_char();
          owe({8'h00, b}, 1'b0, 1'b0);
        end else if ((b & LEAD3_MASK) == LEAD3_MASK) begin
          gathered    = {8'h00, b & LEAD3_BITS} << 12;
          follow_left = 2'd2;
        end else if ((b & LEAD2_MASK) == LEAD2_MASK) begin
          gathered    = {8'h00, b & LEAD2_BITS} << 6;
          follow_left = 2'd1;
        end else begin
          // stray follower where a lead belongs
          owe(16'h0000, 1'b1, 1'b0);
        end
      end else begin
        left_after  = follow_left - 2'd1;
        shift       = 6 * left_after;
        gathered    = gathered | ({8'h00, b & FOLLOW_BITS} << shift);
        follow_left = left_after;
        if (follow_left == 2'd0) begin
          count_char();
          owe(gathered, 1'b0, 1'b0);
          gathered = '0;
        end
      end
    endfunction

    // Compare one accepted result with the oldest owed one
    function void match_result(logic [15:0] cp, logic bad, logic eos, logic [15:0] cnt);
      result_t want;
      if (owed.size() == 0) begin
        errors++;
        if (errors <= SHOWN_ERRORS)
          $display("unexpected result: cp=%h bad=%b eos=%b cnt=%0d", cp, bad, eos, cnt);
      end else begin
        want = owed.pop_front();
        if (want.code_point !== cp || want.bad_sequence !== bad ||
            want.end_of_string !== eos || want.char_count !== cnt) begin
          errors++;
          if (errors <= SHOWN_ERRORS)
            $display({"result differs: expected cp=%h bad=%b eos=%b cnt=%0d,",
                      " got cp=%h bad=%b eos=%b cnt=%0d"},
                     want.code_point, want.bad_sequence, want.end_of_string, want.char_count,
                     cp, bad, eos, cnt);
        end
      end
    endfunction

    function int outstanding();
      return owed.size();
    endfunction
  endclass

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic [7:0]  s_tdata  = 8'h00;
  logic        m_tready = 1'b0;
  logic        s_tready;
  logic        m_tvalid;
  logic [31:0] m_tdata;
  logic        m_tlast;
  logic [0:0]  m_tuser;

  code_point_board board = new();
  int  bytes_sent  = 0;
  int  cycles      = 0;
  int  src_quiet   = 0;
  int  snk_quiet   = 0;

  utf8_to_ucs2_stream_decoder_unit u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Send one byte request after a random gap; keep valid high across back-to-back bytes
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = 0;
    if (src_quiet > 0) begin
      src_quiet--;
    end else if ($urandom_range(0, 19) == 0) begin
      src_quiet = $urandom_range(8, 30);
    end else begin
      gap = $urandom_range(0, 16);
    end
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    board.take_byte(b);
    bytes_sent++;
  endtask

  function automatic logic [7:0] follower_byte();
    if ($urandom_range(0, 7) == 0) return 8'($urandom_range(1, 255));
    return 8'h80 | 8'($urandom_range(0, 63));
  endfunction

  // Send one random string: mostly well-formed characters, some stray and cut sequences
  task automatic send_random_string();
    int n_chars;
    int kind;
    n_chars = $urandom_range(0, 14);
    for (int i = 0; i < n_chars; i++) begin
      kind = $urandom_range(0, 99);
      if (kind < 40) begin
        send_byte(8'($urandom_range(1, 127)));
      end else if (kind < 65) begin
        send_byte(8'hC0 | 8'($urandom_range(0, 31)));
        send_byte(follower_byte());
      end else if (kind < 88) begin
        send_byte(8'hE0 | 8'($urandom_range(0, 31)));
        send_byte(follower_byte());
        send_byte(follower_byte());
      end else if (kind < 94) begin
        send_byte(8'($urandom_range(8'h80, 8'hBF)));
      end else begin
        // cut a sequence short with the terminator
        if ($urandom_range(0, 1) == 0) begin
          send_byte(8'hC0 | 8'($urandom_range(0, 31)));
        end else begin
          send_byte(8'hE0 | 8'($urandom_range(0, 31)));
          if ($urandom_range(0, 1) == 0) send_byte(follower_byte());
        end
        break;
      end
    end
    send_byte(NUL_BYTE);
  endtask

  // Accept results after random stalls and check each one
  initial begin
    int gap;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      gap = 0;
      if (snk_quiet > 0) begin
        snk_quiet--;
      end else if ($urandom_range(0, 19) == 0) begin
        snk_quiet = $urandom_range(8, 30);
      end else begin
        gap = $urandom_range(0, 16);
      end
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      board.match_result(m_tdata[15:0], m_tuser[0], m_tlast, m_tdata[31:16]);
    end
  end

  // Reset, directed bytes, random strings, then drain
  initial begin
    logic [7:0] directed[$];
    directed = '{
      8'h41, 8'h01, 8'h7F, 8'h00,       // ascii extremes, plain end
      8'hC2, 8'hA9, 8'hDF, 8'hBF,       // two-byte forms
      8'hC0, 8'h80,
      8'hE2, 8'h82, 8'hAC,              // three-byte forms
      8'hEF, 8'hBF, 8'hBF,
      8'hFF, 8'hFF, 8'hFF,              // top lead decoded as three-byte
      8'h80, 8'hBF,                     // stray followers
      8'hE2, 8'h82, 8'h00,              // terminator inside a sequence
      8'h00                             // empty string
    };
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) send_byte(directed[i]);

    bytes_sent = 0;
    while (bytes_sent < RANDOM_BYTES) send_random_string();
    s_tvalid <= 1'b0;

    while (board.outstanding() > 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (board.errors == 0 && board.outstanding() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
